FILE: hdl/swsr_pkg.sv
// Package for the single-wire sensor reader: sequencer phase encoding,
// configuration defaults, register indexes and the structs passed between modules.
// No dependencies.
package swsr_pkg;

    // Default width of the tick counter.
    localparam int COUNTER_WIDTH_DEF = 16;

    // Configuration port geometry.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_START_LOW    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RELEASE      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_DELAY = 2'd2;

    // Reset values of the configuration registers.
    localparam logic [15:0] START_LOW_RST    = 16'd20000;
    localparam logic [7:0]  RELEASE_RST      = 8'd40;
    localparam logic [7:0]  SAMPLE_DELAY_RST = 8'd40;

    // Bit positions that frame the three bytes of a reading.
    localparam logic [4:0] BIT_HUM_END  = 5'd8;
    localparam logic [4:0] BIT_SKIP_END = 5'd16;
    localparam logic [4:0] BIT_TEMP_END = 5'd24;

    typedef enum logic [3:0] {
        PH_IDLE    = 4'd0,
        PH_LOW     = 4'd1,
        PH_RELEASE = 4'd2,
        PH_RESP_A  = 4'd3,
        PH_RESP_B  = 4'd4,
        PH_RESP_C  = 4'd5,
        PH_RISE    = 4'd6,
        PH_DELAY   = 4'd7,
        PH_FALL    = 4'd8
    } t_phase;

    typedef struct packed {
        logic [15:0] start_low_ticks;
        logic [7:0]  release_ticks;
        logic [7:0]  sample_delay_ticks;
    } t_cfg;

    typedef struct packed {
        logic       drive_low;
        logic       busy_res;
        logic       done_res;
        logic [7:0] humidity;
        logic [7:0] temperature;
    } t_result;

endpackage

FILE: hdl/single_wire_sensor_reader.sv
// Top level of the single-wire sensor reader: input register, configuration
// registers, output register and the handshakes. Depends on swsr_pkg, swsr_core.
//
// The block takes one sampled tick of the sensor data wire per input transaction
// and returns exactly one result transaction for it. A start request while idle
// drives the wire low for start_low_ticks ticks (the tick carrying the request is
// the first), releases it for release_ticks ticks, follows the sensor's response
// (fall, rise, fall) and then follows 24 bits MSB first; each bit of the first and
// third bytes is sampled sample_delay_ticks ticks after its rising edge. The first
// byte becomes the humidity output, the second is skipped, the third becomes the
// temperature output and raises done_res on the tick its last falling edge is seen.
// Waits for edges have no timeout. Throughput is one transaction per clock while
// the result channel does not stall: the sequencer state in swsr_core is updated
// once per tick by a single short step. An accepted input is held in the input
// register, then its result in the output register. Register values of zero act
// as one; values beyond the tick counter (COUNTER_WIDTH bits) act as its maximum.
// Configuration writes are always accepted and must only be issued while no read
// is in progress and the pipeline is empty; writes to an unknown index are ignored.
module single_wire_sensor_reader
    import swsr_pkg::*;
#(
    parameter int COUNTER_WIDTH = COUNTER_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Input channel.
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic                  i_line_level,
    input  logic                  i_start_request,
    // Result channel.
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic                  o_drive_low,
    output logic                  o_busy_res,
    output logic                  o_done_res,
    output logic [7:0]            o_humidity,
    output logic [7:0]            o_temperature,
    // Configuration write channel.
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic    r_in_valid, n_in_valid;
    logic    r_in_line;
    logic    r_in_start;
    logic    r_out_valid;
    t_result r_out;
    t_result core_result;
    t_cfg    r_cfg;
    logic    advance;
    logic    consume;
    logic    in_accept;

    // The pipeline moves whenever the output register is empty or being drained.
    assign advance    = !r_out_valid || !i_out_stall;
    assign consume    = r_in_valid && advance;
    assign o_in_stall = r_in_valid && !advance;
    assign in_accept  = i_in_valid && !o_in_stall;

    always_comb begin
        if (in_accept) begin
            n_in_valid = 1'b1;
        end else if (consume) begin
            n_in_valid = 1'b0;
        end else begin
            n_in_valid = r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_line  <= i_line_level;
            r_in_start <= i_start_request;
        end
    end

    // Configuration registers; the port never pushes back.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_low_ticks    <= START_LOW_RST;
            r_cfg.release_ticks      <= RELEASE_RST;
            r_cfg.sample_delay_ticks <= SAMPLE_DELAY_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_START_LOW:    r_cfg.start_low_ticks    <= i_cfg_data;
                REG_RELEASE:      r_cfg.release_ticks      <= i_cfg_data[7:0];
                REG_SAMPLE_DELAY: r_cfg.sample_delay_ticks <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    swsr_core #(
        .COUNTER_WIDTH(COUNTER_WIDTH)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (consume),
        .i_line   (r_in_line),
        .i_start  (r_in_start),
        .i_cfg    (r_cfg),
        .o_result (core_result)
    );

    // Output register: holds one finished result while the consumer stalls.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (consume) begin
            r_out <= core_result;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_drive_low   = r_out.drive_low;
    assign o_busy_res    = r_out.busy_res;
    assign o_done_res    = r_out.done_res;
    assign o_humidity    = r_out.humidity;
    assign o_temperature = r_out.temperature;

    // A completed reading always ends the sequence.
    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.done_res) |-> !r_out.busy_res)
        else $error("done result still busy");

    // The wire is only driven while a read is in progress.
    a_drive_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.drive_low) |-> r_out.busy_res)
        else $error("wire driven while idle");

    // Input is held off only while a tick waits behind a stalled result.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && r_out_valid && i_out_stall))
        else $error("input stalled without a full pipeline");

endmodule

FILE: hdl/swsr_core.sv
// Sequencer core of the single-wire sensor reader: phase, tick counter,
// bit counter and byte registers, advanced by one tick per step.
// Depends on swsr_pkg.
module swsr_core
    import swsr_pkg::*;
#(
    parameter int COUNTER_WIDTH = COUNTER_WIDTH_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_step,
    input  logic    i_line,
    input  logic    i_start,
    input  t_cfg    i_cfg,
    output t_result o_result
);

    localparam int TW = (COUNTER_WIDTH > 16) ? COUNTER_WIDTH : 16;
    localparam logic [COUNTER_WIDTH-1:0] CNT_MAX = '1;

    t_phase                   r_phase, n_phase;
    logic [COUNTER_WIDTH-1:0] r_tick, n_tick;
    logic [4:0]               r_bit, n_bit;
    logic [7:0]               r_shift, n_shift;
    logic [7:0]               r_hum, n_hum;
    logic [7:0]               r_temp, n_temp;
    logic                     drive;
    logic                     done;
    logic [COUNTER_WIDTH-1:0] tick_inc;
    logic [COUNTER_WIDTH-1:0] tgt_low, tgt_rel, tgt_smp;

    // A zero count acts as one, and a count beyond the counter acts as its maximum.
    function automatic logic [COUNTER_WIDTH-1:0] f_target(input logic [15:0] v);
        logic [TW-1:0] w;
        w = TW'(v);
        if (w == '0) w = TW'(1);
        if (w > TW'(CNT_MAX)) w = TW'(CNT_MAX);
        return COUNTER_WIDTH'(w);
    endfunction

    assign tgt_low = f_target(i_cfg.start_low_ticks);
    assign tgt_rel = f_target({8'h00, i_cfg.release_ticks});
    assign tgt_smp = f_target({8'h00, i_cfg.sample_delay_ticks});

    always_comb begin
        n_phase  = r_phase;
        n_tick   = r_tick;
        n_bit    = r_bit;
        n_shift  = r_shift;
        n_hum    = r_hum;
        n_temp   = r_temp;
        drive    = 1'b0;
        done     = 1'b0;
        tick_inc = '0;

        if (n_phase == PH_IDLE && i_start) begin
            n_phase = PH_LOW;
            n_tick  = '0;
            n_bit   = '0;
            n_shift = '0;
        end

        tick_inc = (n_tick != CNT_MAX) ? n_tick + COUNTER_WIDTH'(1) : n_tick;

        unique case (n_phase)
            PH_IDLE: begin
            end
            PH_LOW: begin
                drive  = 1'b1;
                n_tick = tick_inc;
                if (tick_inc >= tgt_low) begin
                    n_phase = PH_RELEASE;
                    n_tick  = '0;
                end
            end
            PH_RELEASE: begin
                n_tick = tick_inc;
                if (tick_inc >= tgt_rel) n_phase = PH_RESP_A;
            end
            PH_RESP_A: begin
                if (!i_line) n_phase = PH_RESP_B;
            end
            PH_RESP_B: begin
                if (i_line) n_phase = PH_RESP_C;
            end
            PH_RESP_C: begin
                if (!i_line) begin
                    n_phase = PH_RISE;
                    n_bit   = '0;
                    n_shift = '0;
                end
            end
            PH_RISE: begin
                if (i_line) begin
                    // The middle byte is skipped: only its edges are followed.
                    if (n_bit >= BIT_HUM_END && n_bit < BIT_SKIP_END) begin
                        n_phase = PH_FALL;
                    end else begin
                        n_phase = PH_DELAY;
                        n_tick  = '0;
                    end
                end
            end
            PH_DELAY: begin
                n_tick = tick_inc;
                if (tick_inc >= tgt_smp) begin
                    n_shift = {n_shift[6:0], i_line};
                    n_phase = PH_FALL;
                end
            end
            PH_FALL: begin
                if (!i_line) begin
                    n_bit = n_bit + 5'd1;
                    if (n_bit == BIT_HUM_END) begin
                        n_hum   = n_shift;
                        n_shift = '0;
                        n_phase = PH_RISE;
                    end else if (n_bit >= BIT_TEMP_END) begin
                        n_temp  = n_shift;
                        n_shift = '0;
                        n_bit   = '0;
                        done    = 1'b1;
                        n_phase = PH_IDLE;
                    end else begin
                        n_phase = PH_RISE;
                    end
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase
    end

    always_comb begin
        o_result.drive_low   = drive;
        o_result.busy_res    = (n_phase != PH_IDLE);
        o_result.done_res    = done;
        o_result.humidity    = n_hum;
        o_result.temperature = n_temp;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_tick  <= '0;
            r_bit   <= '0;
            r_shift <= '0;
            r_hum   <= '0;
            r_temp  <= '0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_tick  <= n_tick;
            r_bit   <= n_bit;
            r_shift <= n_shift;
            r_hum   <= n_hum;
            r_temp  <= n_temp;
        end
    end

    // The sample wait is never entered inside the skipped byte.
    a_no_delay_in_skip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DELAY) |-> !(r_bit >= BIT_HUM_END && r_bit < BIT_SKIP_END))
        else $error("sample wait entered inside skipped byte");

    // The bit counter wraps back to zero at the end of the temperature byte.
    a_bit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bit < BIT_TEMP_END)
        else $error("bit counter past last bit");

    // The start pulse always begins from a cleared bit counter and shift byte.
    a_low_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_LOW) |-> (r_bit == '0 && r_shift == '0))
        else $error("start pulse with stale bit state");

endmodule
